// File: rtl/grrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grrf_pkg
// Types and constants shared by the record range filter modules.
// ----------------------------------------------------------------------------
package grrf_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF    = 64;
    localparam int CFG_WIDTH       = 64;
    localparam int Q_DEPTH         = 4;
    localparam int MAX_TAB         = 7;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_W    = 8'h57;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    localparam logic       CFG_LOW  = 1'b0;
    localparam logic       CFG_HIGH = 1'b1;

    localparam logic       ACT_BYTE = 1'b0;
    localparam logic       ACT_END  = 1'b1;

    localparam logic       KIND_LINE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        REC_H     = 3'd0,
        REC_S     = 3'd1,
        REC_L     = 3'd2,
        REC_W     = 3'd3,
        REC_OTHER = 3'd4
    } rec_t;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_BOUNDS     = 4'd1,
        ERR_MISSING    = 4'd2,
        ERR_BAD_ID     = 4'd3,
        ERR_ORIENT     = 4'd4,
        ERR_EMPTY_ID   = 4'd5,
        ERR_LINK_CROSS = 4'd6,
        ERR_WALK_CROSS = 4'd7,
        ERR_INCOMPLETE = 4'd8
    } err_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic        keep;
        logic [2:0]  record_type;
        logic [3:0]  error_code;
        logic [31:0] header_count;
        logic [31:0] segment_count;
        logic [31:0] link_count;
        logic [31:0] walk_count;
        logic [31:0] other_count;
        logic        last;
    } out_t;

    // one finished line and/or end of input, front to back
    typedef struct packed {
        logic summary;
        logic has_line;
        rec_t rtype;
        logic keep;
        err_t err;
    } evt_t;

endpackage
`default_nettype wire

// File: rtl/grrf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grrf_front
// Byte parser: tracks fields and ids of the current line, latches errors and
// posts one event per finished line or end of input.
// ----------------------------------------------------------------------------
module grrf_front
    import grrf_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire in_t                  item,
    input  wire logic [CFG_WIDTH-1:0] low_id,
    input  wire logic [CFG_WIDTH-1:0] high_id,
    output      logic                 evt_push,
    output      evt_t                 evt
);

    rec_t                type_reg, type_next;
    logic                hb_reg, hb_next;
    logic [2:0]          tab_reg, tab_next;
    logic [ID_WIDTH-1:0] acc_reg, acc_next;
    logic                dig_reg, dig_next;
    logic                bad_reg, bad_next;
    logic                ws_reg, ws_next;
    logic                fi_reg, fi_next;
    logic                si_reg, si_next;
    logic                so_reg, so_next;
    logic                lk_reg, lk_next;
    err_t                err_reg, err_next;

    logic [CFG_WIDTH-1:0] acc_ext;
    logic                 in_acc;
    logic                 bad_bounds;
    logic [ID_WIDTH+3:0]  prod;
    logic [3:0]           digit;
    logic                 is_digit;
    logic                 ovf;

    assign acc_ext    = CFG_WIDTH'(acc_reg);
    assign in_acc     = (acc_ext >= low_id) && (acc_ext <= high_id);
    assign bad_bounds = (low_id == '0) || (high_id == '0) || (low_id > high_id);
    assign is_digit   = (item.data_byte >= CH_0) && (item.data_byte <= CH_9);
    assign digit      = 4'(item.data_byte - CH_0);
    // times ten plus digit
    assign prod       = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                        + (ID_WIDTH+4)'(digit);
    assign ovf        = (prod[ID_WIDTH+3:ID_WIDTH] != 4'b0);

    always_comb
    begin
        logic is_end;
        logic is_lf;
        logic is_tab;
        logic finish;
        logic do_fe;
        logic id_push;
        logic walk_done;
        logic [2:0] need;
        logic keep_v;

        type_next = type_reg;
        hb_next   = hb_reg;
        tab_next  = tab_reg;
        acc_next  = acc_reg;
        dig_next  = dig_reg;
        bad_next  = bad_reg;
        ws_next   = ws_reg;
        fi_next   = fi_reg;
        si_next   = si_reg;
        so_next   = so_reg;
        lk_next   = lk_reg;
        err_next  = err_reg;
        evt_push  = 1'b0;
        evt       = '{summary: 1'b0, has_line: 1'b0, rtype: REC_H, keep: 1'b0,
                      err: ERR_NONE};

        is_end    = (item.action == ACT_END);
        is_lf     = !is_end && (item.data_byte == CH_LF);
        is_tab    = !is_end && (item.data_byte == CH_TAB);
        finish    = accept && hb_reg && (is_end || is_lf);
        do_fe     = finish || (accept && is_tab);
        id_push   = 1'b0;
        walk_done = 1'b0;
        need      = 3'd0;
        keep_v    = 1'b0;

        if (accept && err_next == ERR_NONE && bad_bounds)
            err_next = ERR_BOUNDS;

        // first byte names the record
        if (accept && !is_end && !is_lf && !hb_reg)
        begin
            hb_next = 1'b1;
            unique case (item.data_byte)
                CH_H:    type_next = REC_H;
                CH_S:    type_next = REC_S;
                CH_L:    type_next = REC_L;
                CH_W:    type_next = REC_W;
                default: type_next = REC_OTHER;
            endcase
        end

        // field end
        if (do_fe && err_next == ERR_NONE)
        begin
            if (type_next == REC_S && tab_reg == 3'd1)
            begin
                if (!dig_reg || bad_reg) err_next = ERR_BAD_ID;
                else                     lk_next  = in_acc;
            end
            else if (type_next == REC_L && tab_reg == 3'd1)
            begin
                if (!dig_reg || bad_reg) err_next = ERR_BAD_ID;
                else                     fi_next  = in_acc;
            end
            else if (type_next == REC_L && tab_reg == 3'd3)
            begin
                if (!dig_reg || bad_reg)   err_next = ERR_BAD_ID;
                else if (in_acc != fi_reg) err_next = ERR_LINK_CROSS;
                else                       lk_next  = fi_reg;
            end
            else if (type_next == REC_W && tab_reg == 3'd6)
            begin
                walk_done = ws_reg;
            end
        end

        // field byte
        if (accept && !is_end && !is_lf && !is_tab && err_next == ERR_NONE)
        begin
            if ((type_next == REC_S && tab_reg == 3'd1) ||
                (type_next == REC_L && (tab_reg == 3'd1 || tab_reg == 3'd3)))
            begin
                id_push = 1'b1;
            end
            else if (type_next == REC_W && tab_reg == 3'd6)
            begin
                if (item.data_byte == CH_GT || item.data_byte == CH_LT)
                    walk_done = ws_reg;
                else if (!ws_reg)
                    err_next = ERR_ORIENT;
                else
                    id_push = 1'b1;
            end
        end

        if (walk_done)
        begin
            if (!dig_reg)
                err_next = ERR_EMPTY_ID;
            else if (bad_reg)
                err_next = ERR_BAD_ID;
            else
            begin
                if (in_acc) si_next = 1'b1;
                else        so_next = 1'b1;
                if (si_next && so_next)
                    err_next = ERR_WALK_CROSS;
            end
        end

        // walk field closing keeps the verdict
        if (do_fe && type_next == REC_W && tab_reg == 3'd6 && err_reg == ERR_NONE
            && !(accept && bad_bounds))
            lk_next = si_next;

        // a new walk step
        if (accept && !is_end && !is_lf && !is_tab && err_next == ERR_NONE
            && type_next == REC_W && tab_reg == 3'd6
            && (item.data_byte == CH_GT || item.data_byte == CH_LT))
        begin
            ws_next  = 1'b1;
            acc_next = '0;
            dig_next = 1'b0;
            bad_next = 1'b0;
        end

        if (id_push)
        begin
            dig_next = 1'b1;
            if (!bad_reg)
            begin
                if (!is_digit || ovf) bad_next = 1'b1;
                else                  acc_next = prod[ID_WIDTH-1:0];
            end
        end

        if (accept && is_tab)
        begin
            if (tab_reg != 3'(MAX_TAB))
                tab_next = tab_reg + 3'd1;
            acc_next = '0;
            dig_next = 1'b0;
            bad_next = 1'b0;
        end

        if (finish)
        begin
            unique case (type_reg)
                REC_S:   need = 3'd1;
                REC_L:   need = 3'd3;
                REC_W:   need = 3'd6;
                default: need = 3'd0;
            endcase
            if (tab_reg < need && err_next == ERR_NONE)
                err_next = ERR_MISSING;
            if (err_next == ERR_NONE)
            begin
                if (type_reg == REC_H)          keep_v = 1'b1;
                else if (type_reg == REC_OTHER) keep_v = 1'b0;
                else                            keep_v = lk_next;
            end
        end

        if (accept && (is_end || (is_lf && hb_reg)))
        begin
            evt_push     = 1'b1;
            evt.summary  = is_end;
            evt.has_line = hb_reg;
            evt.rtype    = hb_reg ? type_reg : REC_H;
            evt.keep     = keep_v;
            evt.err      = err_next;
        end

        if (finish || (accept && is_end))
        begin
            type_next = REC_H;
            hb_next   = 1'b0;
            tab_next  = '0;
            acc_next  = '0;
            dig_next  = 1'b0;
            bad_next  = 1'b0;
            ws_next   = 1'b0;
            fi_next   = 1'b0;
            si_next   = 1'b0;
            so_next   = 1'b0;
            lk_next   = 1'b0;
        end
        if (accept && is_end)
            err_next = ERR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg <= REC_H;
            hb_reg   <= 1'b0;
            tab_reg  <= '0;
            acc_reg  <= '0;
            dig_reg  <= 1'b0;
            bad_reg  <= 1'b0;
            ws_reg   <= 1'b0;
            fi_reg   <= 1'b0;
            si_reg   <= 1'b0;
            so_reg   <= 1'b0;
            lk_reg   <= 1'b0;
            err_reg  <= ERR_NONE;
        end
        else
        begin
            type_reg <= type_next;
            hb_reg   <= hb_next;
            tab_reg  <= tab_next;
            acc_reg  <= acc_next;
            dig_reg  <= dig_next;
            bad_reg  <= bad_next;
            ws_reg   <= ws_next;
            fi_reg   <= fi_next;
            si_reg   <= si_next;
            so_reg   <= so_next;
            lk_reg   <= lk_next;
            err_reg  <= err_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/grrf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grrf_queue
// Short event queue between parser and result stage.
// ----------------------------------------------------------------------------
module grrf_queue
    import grrf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire evt_t wr_data,
    input  wire logic rd,
    output      logic q_full,
    output      logic q_valid,
    output      evt_t head
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    evt_t          slot_reg [Q_DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == CW'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
            wp_next = (wp_reg == PW'(Q_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        if (rd)
            rp_next = (rp_reg == PW'(Q_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        if (wr && !rd)
            cnt_next = cnt_reg + CW'(1);
        else if (rd && !wr)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            slot_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/grrf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grrf_back
// Result stage: updates the saturating counters, runs the completeness check
// and holds the output word.
// ----------------------------------------------------------------------------
module grrf_back
    import grrf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire evt_t head,
    output      logic q_rd,
    input  wire logic pop,
    output      logic empty,
    output      out_t result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] cnt_reg [5];
    logic [COUNT_WIDTH-1:0] cnt_next [5];
    logic                   phase_reg, phase_next;
    logic                   ov_reg, ov_next;
    out_t                   out_reg, out_next;
    logic                   load;
    logic                   load_sum;

    function automatic logic [31:0] low32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    assign empty  = !ov_reg;
    assign result = out_reg;

    always_comb
    begin
        logic do_line;
        logic bump;
        err_t e;

        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        ov_next    = ov_reg && !pop;
        out_next   = out_reg;
        q_rd       = 1'b0;
        load       = 1'b0;
        load_sum   = 1'b0;
        do_line    = 1'b0;
        bump       = 1'b0;
        e          = head.err;

        if ((!ov_reg || pop) && q_valid)
        begin
            load    = 1'b1;
            ov_next = 1'b1;
            do_line = head.has_line && !(head.summary && phase_reg);
            if (do_line)
            begin
                bump = (head.err == ERR_NONE)
                       && (head.rtype == REC_H || head.rtype == REC_OTHER || head.keep);
                for (int i = 0; i < 5; i++)
                begin
                    if (bump && 3'(i) == head.rtype && cnt_reg[i] != CNT_MAX)
                        cnt_next[i] = cnt_reg[i] + COUNT_WIDTH'(1);
                end
                out_next.result_kind = KIND_LINE;
                out_next.keep        = head.keep;
                out_next.record_type = head.rtype;
                out_next.error_code  = head.err;
                out_next.last        = !head.summary;
                if (head.summary)
                    phase_next = 1'b1;
                else
                    q_rd = 1'b1;
            end
            else
            begin
                load_sum = 1'b1;
                if (e == ERR_NONE && (cnt_reg[0] != COUNT_WIDTH'(1)
                    || cnt_reg[1] == '0 || cnt_reg[2] == '0 || cnt_reg[3] == '0))
                    e = ERR_INCOMPLETE;
                out_next.result_kind = KIND_SUMMARY;
                out_next.keep        = 1'b0;
                out_next.record_type = REC_H;
                out_next.error_code  = e;
                out_next.last        = 1'b1;
                phase_next           = 1'b0;
                q_rd                 = 1'b1;
                for (int i = 0; i < 5; i++)
                    cnt_next[i] = '0;
            end
            out_next.header_count  = low32(load_sum ? cnt_reg[0] : cnt_next[0]);
            out_next.segment_count = low32(load_sum ? cnt_reg[1] : cnt_next[1]);
            out_next.link_count    = low32(load_sum ? cnt_reg[2] : cnt_next[2]);
            out_next.walk_count    = low32(load_sum ? cnt_reg[3] : cnt_next[3]);
            out_next.other_count   = low32(load_sum ? cnt_reg[4] : cnt_next[4]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                cnt_reg[i] <= '0;
            phase_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTH
    a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        load_sum |=> (cnt_reg[0] == '0 && cnt_reg[1] == '0 && cnt_reg[4] == '0))
        else $error("counters not cleared after summary");

    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q_valid && head.summary && head.has_line))
        else $error("split summary without matching queue head");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_reg.last) |-> phase_reg)
        else $error("word without last while no summary pending");
`endif

endmodule
`default_nettype wire

// File: rtl/gfa_record_range_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_record_range_filter
// Keeps GFA records whose segment ids fall in a configured range, one text
// byte per word, with a verdict per line and a summary at end of input.
// ----------------------------------------------------------------------------
// a verdict word goes through the event queue and the output register
// throughput: one byte per cycle while not full; end of input with a pending
//   line yields two words, the line verdict and then the summary
// a four-entry queue between parser and result stage absorbs pop stalls
// reset: asynchronous, clears parser, counters and queue; bounds reset to 1
module gfa_record_range_filter
    import grrf_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output      logic                 full,
    input  wire in_t                  item,
    output      logic                 empty,
    input  wire logic                 pop,
    output      out_t                 result,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CFG_WIDTH-1:0] cfg_data
);

    logic [CFG_WIDTH-1:0] low_reg;
    logic [CFG_WIDTH-1:0] high_reg;
    logic                 accept;
    logic                 evt_push;
    evt_t                 evt;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_rd;
    evt_t                 head;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= CFG_WIDTH'(1);
            high_reg <= CFG_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LOW)
                low_reg <= cfg_data;
            else
                high_reg <= cfg_data;
        end
    end

    grrf_front #(.ID_WIDTH(ID_WIDTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .low_id   (low_reg),
        .high_id  (high_reg),
        .evt_push (evt_push),
        .evt      (evt)
    );

    grrf_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (evt_push),
        .wr_data (evt),
        .rd      (q_rd),
        .q_full  (q_full),
        .q_valid (q_valid),
        .head    (head)
    );

    grrf_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule
`default_nettype wire
